>>> hw/rtl/tpd_pkg.sv
// Shared types and constants for the telemetry payload deframer.
`timescale 1ns / 1ps

package tpd_pkg;

  // Width of the payload length and byte position.
  localparam int LENGTH_BITS = 16;

  // Payload layout constants.
  localparam int MIN_VALID_LEN = 49;
  localparam int GPS_REC_BYTES = 36;
  localparam int HK_MIN_BYTES  = 2;
  localparam int WORD_BYTES    = 8;

  // Depth of the queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result kinds.
  localparam logic [3:0] KIND_FRAME_TIME = 4'd0;
  localparam logic [3:0] KIND_ATT_TIME   = 4'd1;
  localparam logic [3:0] KIND_ATT_Z      = 4'd5;
  localparam logic [3:0] KIND_PRN        = 4'd6;
  localparam logic [3:0] KIND_GPS_TIME   = 4'd10;
  localparam logic [3:0] KIND_HK         = 4'd11;
  localparam logic [3:0] KIND_END        = 4'd12;

  // Parser sections.
  typedef enum logic [2:0] {
    SEC_IDLE  = 3'd0,
    SEC_HEAD  = 3'd1,
    SEC_GCNT  = 3'd2,
    SEC_GPS   = 3'd3,
    SEC_HKCNT = 3'd4,
    SEC_HK    = 3'd5,
    SEC_SKIP  = 3'd6,
    SEC_SHORT = 3'd7
  } sec_t;

  // One queue entry: what one byte produced (a field, an end record, or both).
  typedef struct packed {
    logic        has_field;
    logic [3:0]  kind;
    logic [7:0]  record_index;
    logic [63:0] value;
    logic        has_end;
    logic        frame_valid;
  } entry_t;

endpackage

>>> hw/rtl/tpd_stream_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface tpd_in_if import tpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             byte_value;
  logic                   first_byte;
  logic [LENGTH_BITS-1:0] payload_len;

  modport source (output valid, output byte_value, output first_byte, output payload_len,
                  input ready);
  modport sink (input valid, input byte_value, input first_byte, input payload_len,
                output ready);
endinterface

interface tpd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  record_index;
  logic [63:0] value;
  logic        frame_valid;
  logic        last;

  modport source (output valid, output kind, output record_index, output value,
                  output frame_valid, output last, input ready);
  modport sink (input valid, input kind, input record_index, input value,
                input frame_valid, input last, output ready);
endinterface

>>> hw/rtl/tpd_parser.sv
// Front part: accepts payload bytes, tracks the layout and assembles fields.
`timescale 1ns / 1ps

module tpd_parser import tpd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  tpd_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  sec_t                   sec_r, sec_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0] flen_r, flen_nxt;
  logic [63:0]            shift_r, shift_nxt;
  logic [2:0]             fbc_r, fbc_nxt;
  logic [3:0]             fkind_r, fkind_nxt;
  logic [7:0]             gps_rem_r, gps_rem_nxt;
  logic [7:0]             hk_rem_r, hk_rem_nxt;
  logic [7:0]             rec_r, rec_nxt;

  logic                   accept;
  logic [LENGTH_BITS:0]   p_ext;
  logic [LENGTH_BITS:0]   flen_ext;
  logic                   hk_taken;
  logic [2:0]             need_m1;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Per-byte parse step: section moves, field assembly and result selection.
  always_comb begin
    sec_nxt     = sec_r;
    pos_nxt     = pos_r;
    flen_nxt    = flen_r;
    shift_nxt   = shift_r;
    fbc_nxt     = fbc_r;
    fkind_nxt   = fkind_r;
    gps_rem_nxt = gps_rem_r;
    hk_rem_nxt  = hk_rem_r;
    rec_nxt     = rec_r;
    q_entry     = '0;
    q_push      = 1'b0;
    p_ext       = '0;
    flen_ext    = '0;
    hk_taken    = 1'b0;
    need_m1     = 3'd7;
    if (accept) begin
      // A first byte restarts the parser with a fresh length.
      if (in_ch.first_byte) begin
        flen_nxt    = (in_ch.payload_len == '0) ? LENGTH_BITS'(1) : in_ch.payload_len;
        pos_nxt     = '0;
        shift_nxt   = '0;
        fbc_nxt     = '0;
        fkind_nxt   = KIND_FRAME_TIME;
        gps_rem_nxt = '0;
        hk_rem_nxt  = '0;
        rec_nxt     = '0;
        sec_nxt     = (flen_nxt < LENGTH_BITS'(MIN_VALID_LEN)) ? SEC_SHORT : SEC_HEAD;
      end
      p_ext    = {1'b0, pos_nxt};
      flen_ext = {1'b0, flen_nxt};
      if (sec_nxt != SEC_IDLE) begin
        if (sec_nxt == SEC_GCNT) begin
          // GPS record count byte.
          gps_rem_nxt = in_ch.byte_value;
          rec_nxt     = '0;
          fkind_nxt   = KIND_PRN;
          fbc_nxt     = '0;
          shift_nxt   = '0;
          sec_nxt     = SEC_GPS;
        end else begin
          // A new GPS record needs records left and a whole record of bytes.
          if (sec_nxt == SEC_GPS && fbc_nxt == 3'd0 && fkind_nxt == KIND_PRN) begin
            if (gps_rem_nxt == 8'd0 ||
                (p_ext + (LENGTH_BITS+1)'(GPS_REC_BYTES)) > flen_ext) begin
              sec_nxt = SEC_HKCNT;
            end
          end
          // Housekeeping count byte, read only if room for it and one more byte.
          if (sec_nxt == SEC_HKCNT) begin
            if ((p_ext + (LENGTH_BITS+1)'(HK_MIN_BYTES)) <= flen_ext) begin
              hk_rem_nxt = in_ch.byte_value;
              rec_nxt    = '0;
              fkind_nxt  = KIND_HK;
              fbc_nxt    = '0;
              shift_nxt  = '0;
              sec_nxt    = SEC_HK;
              hk_taken   = 1'b1;
            end else begin
              sec_nxt = SEC_SKIP;
            end
          end
          if (!hk_taken) begin
            // A new housekeeping word needs words left and eight bytes.
            if (sec_nxt == SEC_HK && fbc_nxt == 3'd0) begin
              if (hk_rem_nxt == 8'd0 ||
                  (p_ext + (LENGTH_BITS+1)'(WORD_BYTES)) > flen_ext) begin
                sec_nxt = SEC_SKIP;
              end
            end
            // Field assembly, most significant byte first.
            if (sec_nxt == SEC_HEAD || sec_nxt == SEC_GPS || sec_nxt == SEC_HK) begin
              need_m1   = (fkind_nxt == KIND_PRN) ? 3'd3 : 3'd7;
              shift_nxt = {shift_nxt[55:0], in_ch.byte_value};
              if (fbc_nxt == need_m1) begin
                q_push                 = 1'b1;
                q_entry.has_field      = 1'b1;
                q_entry.kind           = fkind_nxt;
                q_entry.record_index   = (sec_nxt == SEC_HEAD) ? 8'd0 : rec_nxt;
                q_entry.value          = shift_nxt;
                shift_nxt              = '0;
                fbc_nxt                = '0;
                if (sec_nxt == SEC_HEAD) begin
                  if (fkind_nxt >= KIND_ATT_Z) begin
                    sec_nxt = SEC_GCNT;
                  end else begin
                    fkind_nxt = fkind_nxt + 4'd1;
                  end
                end else if (sec_nxt == SEC_GPS) begin
                  if (fkind_nxt >= KIND_GPS_TIME) begin
                    fkind_nxt   = KIND_PRN;
                    gps_rem_nxt = gps_rem_nxt - 8'd1;
                    rec_nxt     = rec_nxt + 8'd1;
                  end else begin
                    fkind_nxt = fkind_nxt + 4'd1;
                  end
                end else begin
                  hk_rem_nxt = hk_rem_nxt - 8'd1;
                  rec_nxt    = rec_nxt + 8'd1;
                end
              end else begin
                fbc_nxt = fbc_nxt + 3'd1;
              end
            end
          end
        end
        // The last byte of the payload closes it with an end record.
        if ((p_ext + (LENGTH_BITS+1)'(1)) >= flen_ext) begin
          q_push              = 1'b1;
          q_entry.has_end     = 1'b1;
          q_entry.frame_valid = (flen_nxt >= LENGTH_BITS'(MIN_VALID_LEN));
          sec_nxt             = SEC_IDLE;
        end
        pos_nxt = pos_nxt + LENGTH_BITS'(1);
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= SEC_IDLE;
      pos_r     <= '0;
      flen_r    <= '0;
      shift_r   <= '0;
      fbc_r     <= '0;
      fkind_r   <= '0;
      gps_rem_r <= '0;
      hk_rem_r  <= '0;
      rec_r     <= '0;
    end else begin
      sec_r     <= sec_nxt;
      pos_r     <= pos_nxt;
      flen_r    <= flen_nxt;
      shift_r   <= shift_nxt;
      fbc_r     <= fbc_nxt;
      fkind_r   <= fkind_nxt;
      gps_rem_r <= gps_rem_nxt;
      hk_rem_r  <= hk_rem_nxt;
      rec_r     <= rec_nxt;
    end
  end

endmodule

>>> hw/rtl/tpd_queue.sv
// Short queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module tpd_queue import tpd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head_entry,
  output logic   empty
);

  entry_t              slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = slots_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // The parser never pushes into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");

  // Occupancy never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

>>> hw/rtl/tpd_emit.sv
// Back part: turns queue entries into result items on the output channel.
`timescale 1ns / 1ps

module tpd_emit import tpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head_entry,
  input  logic      q_empty,
  output logic      q_pop,
  tpd_out_if.source out_ch
);

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [63:0] value_r, value_nxt;
  logic        fv_r, fv_nxt;
  logic        last_r, last_nxt;
  logic        pend_end_r, pend_end_nxt;
  logic        pend_fv_r, pend_fv_nxt;
  logic        load;

  assign load  = !out_valid_r || out_ch.ready;
  assign q_pop = load && !pend_end_r && !q_empty;

  // Output register loading: a pending end record goes before the next entry.
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    fv_nxt        = fv_r;
    last_nxt      = last_r;
    pend_end_nxt  = pend_end_r;
    pend_fv_nxt   = pend_fv_r;
    if (load) begin
      if (pend_end_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_END;
        idx_nxt       = '0;
        value_nxt     = '0;
        fv_nxt        = pend_fv_r;
        last_nxt      = 1'b1;
        pend_end_nxt  = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        if (head_entry.has_field) begin
          kind_nxt     = head_entry.kind;
          idx_nxt      = head_entry.record_index;
          value_nxt    = head_entry.value;
          fv_nxt       = 1'b0;
          last_nxt     = 1'b0;
          pend_end_nxt = head_entry.has_end;
          pend_fv_nxt  = head_entry.frame_valid;
        end else begin
          kind_nxt  = KIND_END;
          idx_nxt   = '0;
          value_nxt = '0;
          fv_nxt    = head_entry.frame_valid;
          last_nxt  = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_end_r  <= 1'b0;
      pend_fv_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_end_r  <= pend_end_nxt;
      pend_fv_r   <= pend_fv_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    value_r <= value_nxt;
    fv_r    <= fv_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.record_index = idx_r;
  assign out_ch.value        = value_r;
  assign out_ch.frame_valid  = fv_r;
  assign out_ch.last         = last_r;

  // A pending end record always trails a field item that is on the output.
  a_pend_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    pend_end_r |-> (out_valid_r && !last_r)) else $error("end record pending without field");

  // Only the end record carries last, and it has a zero value and index.
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (kind_r == KIND_END && value_r == '0 && idx_r == '0))
    else $error("last set on a non-end item");

endmodule

>>> hw/rtl/telemetry_payload_deframer.sv
// Top level of the telemetry payload deframer.
`timescale 1ns / 1ps

// The block takes one payload byte per clock cycle whenever its four-entry result queue
// has room, and emits assembled big-endian fields (frame time, attitude record, GPS
// records, housekeeping words) as raw 64-bit items, followed by an end record on the
// payload's last byte. A byte yields zero, one or two items; the output stage drains one
// item per cycle while the receiver is ready, and a byte that completes a field and closes
// the payload takes a single queue entry, so the queue absorbs it without stalling the input.
// The parser step (one shift and a few position compares) is the loop that sets the rate.
module telemetry_payload_deframer import tpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tpd_in_if.sink    in_ch,
  tpd_out_if.source out_ch
);

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t push_entry;
  entry_t head_entry;

  // Front part: byte parsing.
  tpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Decoupling queue.
  tpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  // Back part: result output.
  tpd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

>>> dv/tb_telemetry_payload_deframer.sv
// Self-checking testbench for the telemetry payload deframer.
`timescale 1ns / 1ps

module tb_telemetry_payload_deframer;
  import tpd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 210;

  // One input item: a payload byte with its framing fields.
  typedef struct {
    logic [7:0]             byte_value;
    logic                   first_byte;
    logic [LENGTH_BITS-1:0] payload_len;
  } byte_item_t;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  rec_idx;
    logic [63:0] value;
    logic        frame_valid;
    logic        last;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  tpd_in_if  in_ch ();
  tpd_out_if out_ch ();

  telemetry_payload_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  byte_item_t  byte_q[$];
  field_rec_t  pending_fields[$];
  logic [7:0]  body_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int errors;
  int bytes_taken;
  int starts_taken;
  int fields_checked;
  int cycle_count;

  // Shadow copy of the parser state.
  sec_t                   dp_sec;
  logic [LENGTH_BITS-1:0] dp_pos;
  logic [LENGTH_BITS-1:0] dp_len;
  logic [63:0]            dp_shift;
  int unsigned            dp_count;
  logic [3:0]             dp_kind;
  logic [7:0]             dp_gps_left;
  logic [7:0]             dp_hk_left;
  logic [7:0]             dp_rec;

  // Append one predicted result item to the list of results still to come.
  task automatic queue_result(input field_rec_t r);
    pending_fields.insert(pending_fields.size(), r);
  endtask

  // Append one byte to the payload body under construction.
  task automatic add_body_byte(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  // Advance the shadow parser by one byte and queue the fields it completes.
  task automatic deframe_byte(input byte_item_t it);
    int unsigned pos;
    int unsigned need;
    logic [7:0]  idx;
    bit          took_count;
    if (it.first_byte) begin
      dp_len      = (it.payload_len == '0) ? LENGTH_BITS'(1) : it.payload_len;
      dp_pos      = 0;
      dp_shift    = 0;
      dp_count    = 0;
      dp_kind     = KIND_FRAME_TIME;
      dp_gps_left = 0;
      dp_hk_left  = 0;
      dp_rec      = 0;
      dp_sec      = (dp_len < MIN_VALID_LEN) ? SEC_SHORT : SEC_HEAD;
    end
    if (dp_sec == SEC_IDLE) return;
    pos = 32'(dp_pos);
    took_count = 1'b0;

    if (dp_sec == SEC_GCNT) begin
      dp_gps_left = it.byte_value;
      dp_rec      = 0;
      dp_kind     = KIND_PRN;
      dp_count    = 0;
      dp_shift    = 0;
      dp_sec      = SEC_GPS;
    end else begin
      // A GPS record starts only when one is announced and all 36 bytes fit.
      if (dp_sec == SEC_GPS && dp_count == 0 && dp_kind == KIND_PRN) begin
        if (dp_gps_left == 0 || pos + GPS_REC_BYTES > dp_len) dp_sec = SEC_HKCNT;
      end
      if (dp_sec == SEC_HKCNT) begin
        if (pos + HK_MIN_BYTES <= dp_len) begin
          dp_hk_left = it.byte_value;
          dp_rec     = 0;
          dp_kind    = KIND_HK;
          dp_count   = 0;
          dp_shift   = 0;
          dp_sec     = SEC_HK;
          took_count = 1'b1;
        end else begin
          dp_sec = SEC_SKIP;
        end
      end
      if (!took_count) begin
        if (dp_sec == SEC_HK && dp_count == 0) begin
          if (dp_hk_left == 0 || pos + WORD_BYTES > dp_len) dp_sec = SEC_SKIP;
        end
        // Shift the byte into the open field and emit it once complete.
        if (dp_sec == SEC_HEAD || dp_sec == SEC_GPS || dp_sec == SEC_HK) begin
          need = (dp_kind == KIND_PRN) ? 4 : WORD_BYTES;
          idx  = (dp_sec == SEC_HEAD) ? 8'd0 : dp_rec;
          dp_shift = {dp_shift[55:0], it.byte_value};
          dp_count++;
          if (dp_count >= need) begin
            queue_result('{dp_kind, idx, dp_shift, 1'b0, 1'b0});
            dp_shift = 0;
            dp_count = 0;
            if (dp_sec == SEC_HEAD) begin
              if (dp_kind >= KIND_ATT_Z) dp_sec = SEC_GCNT;
              else dp_kind++;
            end else if (dp_sec == SEC_GPS) begin
              if (dp_kind >= KIND_GPS_TIME) begin
                dp_kind = KIND_PRN;
                dp_gps_left--;
                dp_rec++;
              end else begin
                dp_kind++;
              end
            end else begin
              dp_hk_left--;
              dp_rec++;
            end
          end
        end
      end
    end

    // The last byte of the payload closes it with an end record.
    if (pos + 1 >= dp_len) begin
      queue_result('{KIND_END, 8'd0, 64'd0, dp_len >= MIN_VALID_LEN, 1'b1});
      dp_sec = SEC_IDLE;
    end
    dp_pos = LENGTH_BITS'(pos + 1);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first,
                           input logic [LENGTH_BITS-1:0] len);
    byte_item_t it;
    it = '{b, first, len};
    byte_q.insert(byte_q.size(), it);
  endtask

  // Lay out a payload body: header, GPS count and records, housekeeping count and words.
  task automatic build_body(input int unsigned gps_field, input int unsigned gps_recs,
                            input int unsigned hk_field, input int unsigned hk_words);
    body_q.delete();
    repeat (48) add_body_byte(8'($urandom_range(0, 255)));
    add_body_byte(8'(gps_field));
    repeat (gps_recs * GPS_REC_BYTES) add_body_byte(8'($urandom_range(0, 255)));
    add_body_byte(8'(hk_field));
    repeat (hk_words * WORD_BYTES) add_body_byte(8'($urandom_range(0, 255)));
  endtask

  // Send n bytes of a payload of the given length; the body is padded with random bytes.
  task automatic send_payload(input int unsigned len, input int unsigned n);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = (i < body_q.size()) ? body_q[i] : 8'($urandom_range(0, 255));
      if (i == 0) push_byte(b, 1'b1, LENGTH_BITS'(len));
      else push_byte(b, 1'b0, LENGTH_BITS'($urandom_range(0, 65535)));
    end
  endtask

  // Mostly well-formed payloads with random content, plus short, raw and stray bytes.
  task automatic gen_random_bytes(input int target);
    int          taken;
    int unsigned roll;
    int unsigned gps_recs;
    int unsigned hk_words;
    int unsigned gps_field;
    int unsigned hk_field;
    int unsigned full;
    int unsigned len;
    int unsigned n;
    taken = 0;
    while (taken < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        gps_recs  = $urandom_range(0, 2);
        hk_words  = $urandom_range(0, 3);
        gps_field = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : gps_recs;
        hk_field  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : hk_words;
        build_body(gps_field, gps_recs, hk_field, hk_words);
        full = body_q.size();
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_VALID_LEN, full)
                                           : full + $urandom_range(0, 10);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
      end else if (roll < 85) begin
        body_q.delete();
        len = $urandom_range(0, MIN_VALID_LEN - 1);
        n   = (len == 0) ? 1 : len;
      end else if (roll < 93) begin
        // Stray bytes between payloads; they count only if a payload is still open.
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), 1'b0,
                    LENGTH_BITS'($urandom_range(0, 65535)));
        continue;
      end else begin
        body_q.delete();
        len = $urandom_range(MIN_VALID_LEN, 200);
        n   = len;
      end
      send_payload(len, n);
      taken += n;
    end
  endtask

  task automatic wait_for_drain();
    while (byte_q.size() != 0 || in_ch.valid || pending_fields.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Byte driver: offers the next queued byte unless idling this cycle.
  always @(posedge clk) begin : drive_bytes
    byte_item_t nxt;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.byte_value  <= 8'd0;
      in_ch.first_byte  <= 1'b0;
      in_ch.payload_len <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.byte_value  <= nxt.byte_value;
        in_ch.first_byte  <= nxt.first_byte;
        in_ch.payload_len <= nxt.payload_len;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each accepted result and predicts from each accepted byte.
  always @(posedge clk) begin : watch_channels
    field_rec_t got;
    field_rec_t want;
    byte_item_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.record_index, out_ch.value, out_ch.frame_valid,
                out_ch.last};
        fields_checked++;
        if (pending_fields.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                   $time, got.kind, got.value);
        end else begin
          want = pending_fields.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("record_index", want.rec_idx, got.rec_idx);
          compare_field("value", want.value, got.value);
          compare_field("frame_valid", want.frame_valid, got.frame_valid);
          compare_field("last", want.last, got.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.byte_value, in_ch.first_byte, in_ch.payload_len};
        bytes_taken++;
        if (seen.first_byte) starts_taken++;
        deframe_byte(seen);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.byte_value  = 8'd0;
    in_ch.first_byte  = 1'b0;
    in_ch.payload_len = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_req          = 0;
    errors            = 0;
    bytes_taken       = 0;
    starts_taken      = 0;
    fields_checked    = 0;
    cycle_count       = 0;
    dp_sec            = SEC_IDLE;
    dp_pos            = '0;
    dp_len            = '0;
    dp_shift          = '0;
    dp_count          = 0;
    dp_kind           = KIND_FRAME_TIME;
    dp_gps_left       = '0;
    dp_hk_left        = '0;
    dp_rec            = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes before any payload has started are ignored.
    push_byte(8'h00, 1'b0, 16'h0000);
    push_byte(8'hFF, 1'b0, 16'hFFFF);
    push_byte(8'h5A, 1'b0, 16'hA5A5);
    // Zero length behaves as length one; lengths one and two are short.
    body_q.delete();
    send_payload(0, 1);
    add_body_byte(8'hFF);
    send_payload(1, 1);
    body_q.delete();
    send_payload(2, 2);
    // A payload at the largest length abandoned by a restart.
    send_payload(16'hFFFF, 6);
    // Just too short to be valid, all zero bytes.
    body_q.delete();
    repeat (48) add_body_byte(8'h00);
    send_payload(48, 48);
    // Shortest valid payload, all ones: header only, GPS count on the last byte.
    body_q.delete();
    repeat (49) add_body_byte(8'hFF);
    send_payload(49, 49);
    // Complete layout with one GPS record and two housekeeping words.
    build_body(1, 1, 2, 2);
    send_payload(body_q.size(), body_q.size());
    // Bytes after the end record are ignored.
    push_byte(8'hC3, 1'b0, 16'h1234);
    push_byte(8'h3C, 1'b0, 16'hEDCB);
    wait_for_drain();

    // Random traffic under three idling mixes; the last one opens with a long stall.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req++;
        end
      endcase
      gen_random_bytes(PHASE_BYTES);
      wait_for_drain();
    end

    $display("Summary: %0d bytes accepted in %0d payload starts, %0d results checked.",
             bytes_taken, starts_taken, fields_checked);
    $display("Covered short, zero-length, truncated and restarted payloads under mixed %s",
             "idling and a long output stall.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
